[rtl/bvmc_pkg.sv]
package bvmc_pkg;

  // field widths
  localparam int AngleW   = 17;
  localparam int RateW    = 20;
  localparam int SpeedW   = 21;
  localparam int GainW    = 20;
  localparam int DriveW   = 11;
  localparam int DutyW    = 10;
  localparam int ErrW     = 24;
  localparam int DiffW    = AngleW + 1;
  localparam int LeastW   = SpeedW + 2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  localparam int OutputLimitDef   = 1000;
  localparam int IntegralLimitDef = 1000;

  // Q.8 signals, Q.12 gains, loop terms scaled down by 2^20
  localparam int SigOne      = 256;
  localparam int ScaleShift  = 20;
  localparam int FiltShift   = 12;
  localparam int FiltRound   = 2048;
  localparam int ErrMax      = 8388607;
  localparam int ErrMin      = -8388608;

  localparam logic [GainW-1:0] FiltOld = 20'd3441;
  localparam logic [GainW-1:0] FiltNew = 20'd655;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ZERO_ANGLE  = 3'd0,
    REG_BALANCE_KP  = 3'd1,
    REG_BALANCE_KD  = 3'd2,
    REG_VELOCITY_KP = 3'd3,
    REG_VELOCITY_KI = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [AngleW-1:0] zero_angle;
    logic [GainW-1:0]         balance_kp;
    logic [GainW-1:0]         balance_kd;
    logic [GainW-1:0]         velocity_kp;
    logic [GainW-1:0]         velocity_ki;
  } cfg_t;

  localparam cfg_t CfgRst = '{
    zero_angle:   17'sd0,
    balance_kp:   20'd348160,
    balance_kd:   20'd20480,
    velocity_kp:  20'd110592,
    velocity_ki:  20'd553
  };

  typedef struct packed {
    logic start;
    logic clear;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_sts_t;

endpackage

[rtl/bvmc_if.sv]
interface bvmc_cfg_if;
  import bvmc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface bvmc_in_if;
  import bvmc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [AngleW-1:0] tilt_angle;
  logic signed [RateW-1:0]  tilt_rate;
  logic signed [SpeedW-1:0] left_speed;
  logic signed [SpeedW-1:0] right_speed;
  modport source (output valid, tilt_angle, tilt_rate, left_speed, right_speed, input ready);
  modport sink (input valid, tilt_angle, tilt_rate, left_speed, right_speed, output ready);
endinterface

interface bvmc_out_if;
  import bvmc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] drive;
  logic [DutyW-1:0]         duty;
  logic                     left_reverse;
  logic                     right_forward;
  modport source (output valid, drive, duty, left_reverse, right_forward, input ready);
  modport sink (input valid, drive, duty, left_reverse, right_forward, output ready);
endinterface

[rtl/bvmc_cfg.sv]
module bvmc_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  bvmc_cfg_if.sink       cfg_i,
  output bvmc_pkg::cfg_t cfg_o
);
  import bvmc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ZERO_ANGLE:   cfg_d.zero_angle  = $signed(cfg_i.data[AngleW-1:0]);
        REG_BALANCE_KP:   cfg_d.balance_kp  = cfg_i.data[GainW-1:0];
        REG_BALANCE_KD:   cfg_d.balance_kd  = cfg_i.data[GainW-1:0];
        REG_VELOCITY_KP:  cfg_d.velocity_kp = cfg_i.data[GainW-1:0];
        REG_VELOCITY_KI:  cfg_d.velocity_ki = cfg_i.data[GainW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/bvmc_smac.sv]
module bvmc_smac #(
  parameter int AccW = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bvmc_pkg::mac_cmd_t           cmd_i,
  input  logic signed [AccW-1:0]       mcand_i,
  input  logic [bvmc_pkg::GainW-1:0]   mplier_i,
  input  logic signed [AccW-1:0]       init_i,
  output bvmc_pkg::mac_sts_t           sts_o,
  output logic signed [AccW-1:0]       acc_o
);
  import bvmc_pkg::*;

  localparam int CntW = $clog2(GainW);
  localparam logic [CntW-1:0] CntLast = CntW'(GainW - 1);

  logic                   busy_q, busy_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [AccW-1:0] mcand_q, mcand_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [GainW-1:0]       mplier_q, mplier_d;

  // one multiplier bit per cycle, lsb first, multiplicand walks left
  always_comb begin
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (cmd_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      if (cmd_i.clear) begin
        acc_d = init_i;
      end
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && (cnt_q == CntLast);
  assign acc_o      = acc_q;

endmodule

[rtl/bvmc_core.sv]
module bvmc_core #(
  parameter int OUTPUT_LIMIT   = bvmc_pkg::OutputLimitDef,
  parameter int INTEGRAL_LIMIT = bvmc_pkg::IntegralLimitDef,
  localparam int OutW = $clog2(OUTPUT_LIMIT + 1) + 1,
  localparam int TotW = (OutW > bvmc_pkg::DriveW) ? OutW : bvmc_pkg::DriveW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bvmc_pkg::cfg_t         cfg_i,
  bvmc_in_if.sink                in_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic signed [TotW-1:0] total_o
);
  import bvmc_pkg::*;

  localparam int IntLim = INTEGRAL_LIMIT * SigOne;
  localparam int IntW   = $clog2(IntLim + 1) + 1;
  localparam int OpW    = (IntW > ErrW) ? IntW : ErrW;
  localparam int AccW   = OpW + GainW + 1;
  localparam int TrW    = AccW - ScaleShift;
  localparam int FltW   = AccW - FiltShift;
  localparam int SumW   = OpW + 1;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_UP_KP   = 11'b00000000010,
    S_UP_KD   = 11'b00000000100,
    S_FLT_OLD = 11'b00000001000,
    S_FLT_NEW = 11'b00000010000,
    S_FILT    = 11'b00000100000,
    S_VEL_KP  = 11'b00001000000,
    S_VEL_KI  = 11'b00010000000,
    S_VEL     = 11'b00100000000,
    S_SUM     = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   issue_q, issue_d;

  logic signed [ErrW-1:0]   fse_q, fse_d;
  logic signed [IntW-1:0]   integ_q, integ_d;
  logic signed [DiffW-1:0]  diff_q, diff_d;
  logic signed [RateW-1:0]  rate_q, rate_d;
  logic signed [LeastW-1:0] least_q, least_d;
  logic signed [TrW-1:0]    upright_q, upright_d;
  logic signed [TrW-1:0]    vel_q, vel_d;
  logic signed [TotW-1:0]   total_q, total_d;

  mac_cmd_t               mac_cmd;
  mac_sts_t               mac_sts;
  logic signed [AccW-1:0] mac_mcand;
  logic [GainW-1:0]       mac_mplier;
  logic signed [AccW-1:0] mac_init;
  logic signed [AccW-1:0] mac_acc;

  logic signed [LeastW-1:0] speed_sum;
  logic signed [FltW-1:0]   flt_shift;
  logic signed [SumW-1:0]   int_sum;
  logic signed [TrW:0]      tot_sum;

  // divide by 2^20, rounding toward zero
  function automatic logic signed [TrW-1:0] scale_down(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] b;
    b = a + $signed({{(AccW-ScaleShift){1'b0}}, {ScaleShift{a[AccW-1]}}});
    return b[AccW-1:ScaleShift];
  endfunction

  bvmc_smac #(
    .AccW (AccW)
  ) u_smac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mac_cmd),
    .mcand_i  (mac_mcand),
    .mplier_i (mac_mplier),
    .init_i   (mac_init),
    .sts_o    (mac_sts),
    .acc_o    (mac_acc)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign total_o     = total_q;

  assign speed_sum = LeastW'(in_i.left_speed) + LeastW'(in_i.right_speed);
  assign flt_shift = $signed(mac_acc[AccW-1:FiltShift]);
  assign int_sum   = SumW'(integ_q) + SumW'(fse_q);
  assign tot_sum   = (TrW+1)'(upright_q) + (TrW+1)'(vel_q);

  // operand selection for the shared multiplier
  always_comb begin
    mac_cmd.start = 1'b0;
    mac_cmd.clear = 1'b0;
    mac_mcand     = '0;
    mac_mplier    = '0;
    mac_init      = '0;
    case (state_q)
      S_UP_KP: begin
        mac_cmd.start = issue_q;
        mac_cmd.clear = 1'b1;
        mac_mcand     = AccW'(diff_q);
        mac_mplier    = cfg_i.balance_kp;
      end
      S_UP_KD: begin
        mac_cmd.start = issue_q;
        mac_mcand     = AccW'(rate_q);
        mac_mplier    = cfg_i.balance_kd;
      end
      S_FLT_OLD: begin
        mac_cmd.start = issue_q;
        mac_cmd.clear = 1'b1;
        mac_mcand     = AccW'(fse_q);
        mac_mplier    = FiltOld;
        mac_init      = AccW'(FiltRound);
      end
      S_FLT_NEW: begin
        mac_cmd.start = issue_q;
        mac_mcand     = AccW'(least_q);
        mac_mplier    = FiltNew;
      end
      S_VEL_KP: begin
        mac_cmd.start = issue_q;
        mac_cmd.clear = 1'b1;
        mac_mcand     = AccW'(fse_q);
        mac_mplier    = cfg_i.velocity_kp;
      end
      S_VEL_KI: begin
        mac_cmd.start = issue_q;
        mac_mcand     = AccW'(integ_q);
        mac_mplier    = cfg_i.velocity_ki;
      end
      default: begin
        mac_cmd.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    issue_d   = 1'b0;
    fse_d     = fse_q;
    integ_d   = integ_q;
    diff_d    = diff_q;
    rate_d    = rate_q;
    least_d   = least_q;
    upright_d = upright_q;
    vel_d     = vel_q;
    total_d   = total_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          diff_d  = DiffW'(in_i.tilt_angle) - DiffW'(cfg_i.zero_angle);
          rate_d  = in_i.tilt_rate;
          least_d = -speed_sum;
          state_d = S_UP_KP;
          issue_d = 1'b1;
        end
      end
      S_UP_KP: begin
        if (mac_sts.done) begin
          state_d = S_UP_KD;
          issue_d = 1'b1;
        end
      end
      S_UP_KD: begin
        if (mac_sts.done) begin
          state_d = S_FLT_OLD;
          issue_d = 1'b1;
        end
      end
      S_FLT_OLD: begin
        // upright sum is still in the accumulator on the launch cycle
        if (issue_q) begin
          upright_d = scale_down(mac_acc);
        end
        if (mac_sts.done) begin
          state_d = S_FLT_NEW;
          issue_d = 1'b1;
        end
      end
      S_FLT_NEW: begin
        if (mac_sts.done) begin
          state_d = S_FILT;
        end
      end
      S_FILT: begin
        if (flt_shift > ErrMax) begin
          fse_d = ErrW'(ErrMax);
        end else if (flt_shift < ErrMin) begin
          fse_d = ErrW'(ErrMin);
        end else begin
          fse_d = flt_shift[ErrW-1:0];
        end
        state_d = S_VEL_KP;
        issue_d = 1'b1;
      end
      S_VEL_KP: begin
        if (issue_q) begin
          if (int_sum > IntLim) begin
            integ_d = IntW'(IntLim);
          end else if (int_sum < -IntLim) begin
            integ_d = IntW'(-IntLim);
          end else begin
            integ_d = int_sum[IntW-1:0];
          end
        end
        if (mac_sts.done) begin
          state_d = S_VEL_KI;
          issue_d = 1'b1;
        end
      end
      S_VEL_KI: begin
        if (mac_sts.done) begin
          state_d = S_VEL;
        end
      end
      S_VEL: begin
        vel_d   = -scale_down(mac_acc);
        state_d = S_SUM;
      end
      S_SUM: begin
        if (tot_sum > OUTPUT_LIMIT) begin
          total_d = TotW'(OUTPUT_LIMIT);
        end else if (tot_sum < -OUTPUT_LIMIT) begin
          total_d = TotW'(-OUTPUT_LIMIT);
        end else begin
          total_d = tot_sum[TotW-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      issue_q <= 1'b0;
      fse_q   <= '0;
      integ_q <= '0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      fse_q   <= fse_d;
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q    <= diff_d;
    rate_q    <= rate_d;
    least_q   <= least_d;
    upright_q <= upright_d;
    vel_q     <= vel_d;
    total_q   <= total_d;
  end

  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= IntLim) && (integ_q >= -IntLim))
    else $error("speed integral outside its limit");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> ((total_q <= OUTPUT_LIMIT) && (total_q >= -OUTPUT_LIMIT)))
    else $error("offered drive outside the output limit");

  a_mac_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_cmd.start |-> !mac_sts.busy)
    else $error("multiplier launched while busy");

  a_accept_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (mac_cmd.start && mac_cmd.clear))
    else $error("accepted word did not launch the upright product");

endmodule

[rtl/bvmc_out.sv]
module bvmc_out #(
  parameter int OUTPUT_LIMIT = bvmc_pkg::OutputLimitDef,
  localparam int OutW = $clog2(OUTPUT_LIMIT + 1) + 1,
  localparam int TotW = (OutW > bvmc_pkg::DriveW) ? OutW : bvmc_pkg::DriveW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  output logic                   res_ready_o,
  input  logic signed [TotW-1:0] total_i,
  bvmc_out_if.source             out_o
);
  import bvmc_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [DriveW-1:0] drive_q, drive_d;
  logic [DutyW-1:0]         duty_q, duty_d;
  logic                     rev_q, rev_d;
  logic                     fwd_q, fwd_d;
  logic signed [TotW-1:0]   mag;

  assign res_ready_o = !valid_q || out_o.ready;
  assign mag         = total_i[TotW-1] ? -total_i : total_i;

  always_comb begin
    valid_d = valid_q;
    drive_d = drive_q;
    duty_d  = duty_q;
    rev_d   = rev_q;
    fwd_d   = fwd_q;
    if (res_valid_i && res_ready_o) begin
      valid_d = 1'b1;
      drive_d = total_i[DriveW-1:0];
      duty_d  = mag[DutyW-1:0];
      rev_d   = total_i[TotW-1];
      fwd_d   = !total_i[TotW-1] && (total_i != '0);
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drive_q <= drive_d;
    duty_q  <= duty_d;
    rev_q   <= rev_d;
    fwd_q   <= fwd_d;
  end

  assign out_o.valid         = valid_q;
  assign out_o.drive         = drive_q;
  assign out_o.duty          = duty_q;
  assign out_o.left_reverse  = rev_q;
  assign out_o.right_forward = fwd_q;

endmodule

[rtl/balance_velocity_motor_control.sv]
// channel   role    word
// cfg_i     sink    index (register 0..4), data (20 bit, zero angle uses low 17)
// in_i      sink    tilt_angle, tilt_rate, left_speed, right_speed
// out_o     source  drive, duty, left_reverse, right_forward
//
// one word in flight: six products on one shift-add multiplier, each a launch step plus a
// step per bit of the 20-bit gain; the filter clamp (S_FILT) runs between the fourth and
// fifth product, the velocity and sum steps (S_VEL, S_SUM) after the sixth, then S_DONE
// hands the result to the output register; the multiplier bit loop takes most of the time.
// reset clears the filter state, the integral, the handshakes and restores gains.
// the output register frees the core, so the next word is taken while a result waits;
// a result still held at the end of the next word stalls the core until it is taken.
module balance_velocity_motor_control #(
  parameter int OUTPUT_LIMIT   = bvmc_pkg::OutputLimitDef,
  parameter int INTEGRAL_LIMIT = bvmc_pkg::IntegralLimitDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bvmc_cfg_if.sink   cfg_i,
  bvmc_in_if.sink    in_i,
  bvmc_out_if.source out_o
);
  import bvmc_pkg::*;

  localparam int OutW = $clog2(OUTPUT_LIMIT + 1) + 1;
  localparam int TotW = (OutW > DriveW) ? OutW : DriveW;

  cfg_t                   cfg;
  logic                   res_valid;
  logic                   res_ready;
  logic signed [TotW-1:0] total;

  bvmc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bvmc_core #(
    .OUTPUT_LIMIT   (OUTPUT_LIMIT),
    .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .total_o     (total)
  );

  bvmc_out #(
    .OUTPUT_LIMIT (OUTPUT_LIMIT)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .total_i     (total),
    .out_o       (out_o)
  );

endmodule
